// File: src/twmc_pkg.sv
// Shared types, register indexes and constants of the two-wheel move controller.
`timescale 1ns / 1ps

package twmc_pkg;

  // Default count width of the held encoder state
  localparam int COUNT_BITS_DEF = 32;

  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_MS   = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0] RST_POS_GAIN   = 16'd256;
  localparam logic [GAIN_W-1:0] RST_SYNC_GAIN  = 16'd256;
  localparam logic [GAIN_W-1:0] RST_DRIFT_GAIN = 16'd0;
  localparam logic [GAIN_W-1:0] RST_STALL_MS   = 16'd100;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Drive limits
  localparam logic signed [15:0] L_MIN = -16'sd113;
  localparam logic signed [15:0] L_MAX = 16'sd112;
  localparam logic signed [15:0] R_MIN = -16'sd127;
  localparam logic signed [15:0] R_MAX = 16'sd127;

  // Speed products above this (Q8.8 of 30) leave the speed term unscaled
  localparam logic signed [42:0] SYNC_LIMIT = 43'sd7680;

  // Input request payload
  typedef struct packed {
    logic               operation;
    logic signed [31:0] move_counts;
    logic               turn_mode;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic        [31:0] now_ms;
  } in_req_t;

  // Result request payload
  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              done_res;
  } out_req_t;

  // Datapath command, one per cycle
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_PREP,
    STEP_ML,
    STEP_MR,
    STEP_MV,
    STEP_MK,
    STEP_MC,
    STEP_WC,
    STEP_SYNC,
    STEP_FIN
  } step_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic run;       // held request is a tick during an active move
    logic out_free;  // output register can take a result this cycle
  } dp_sts_t;

endpackage

// File: src/twmc_dp.sv
// Datapath: config registers, move state, shared gain multiplier and output register.
`timescale 1ns / 1ps

module twmc_dp #(
  parameter int COUNT_BITS = twmc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  twmc_pkg::step_t                     step,
  output twmc_pkg::dp_sts_t                   sts,
  input  twmc_pkg::in_req_t                   in_data,
  input  logic                                cfg_we,
  input  logic [twmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twmc_pkg::GAIN_W-1:0]         cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output twmc_pkg::out_req_t                  out_data
);

  localparam int CB = COUNT_BITS;

  // Saturate a 64-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) return 16'sh7fff;
    else if (x < -64'sd32768) return 16'sh8000;
    else return x[15:0];
  endfunction

  // Saturate a 17-bit sum to 16 bits
  function automatic logic signed [15:0] sat17(input logic signed [16:0] s);
    if (s > 17'sd32767) return 16'sh7fff;
    else if (s < -17'sd32768) return 16'sh8000;
    else return s[15:0];
  endfunction

  function automatic logic signed [15:0] add_sat(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    return sat17(17'(a) + 17'(b));
  endfunction

  function automatic logic signed [15:0] sub_sat(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    return sat17(17'(a) - 17'(b));
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [15:0] x,
                                                 input logic signed [15:0] lo,
                                                 input logic signed [15:0] hi);
    if (x < lo) return lo;
    else if (x > hi) return hi;
    else return x;
  endfunction

  // Limit a count error to +-2^24 ahead of the multiply
  function automatic logic signed [25:0] clamp_err(input logic signed [63:0] x);
    if (x > 64'sd16777216) return 26'sd16777216;
    else if (x < -64'sd16777216) return -26'sd16777216;
    else return x[25:0];
  endfunction

  // Q8.8 scale: divide by 256 toward zero, then saturate
  function automatic logic signed [15:0] qscale(input logic signed [42:0] p);
    logic signed [42:0] t;
    t = p + (p[42] ? 43'sd255 : 43'sd0);
    return sat16(64'(t >>> 8));
  endfunction

  // Configuration registers
  logic [twmc_pkg::GAIN_W-1:0] lpg_r, rpg_r, sg_r, dg_r, stall_ms_r;

  // Move state
  logic signed [CB-1:0] lt_r, rt_r, lo_r, ro_r, lp_r, rp_r;
  logic                 armed_r, fwd_r, turn_r, active_r;
  logic [31:0]          stamp_r;

  // Working registers
  twmc_pkg::in_req_t  in_r;
  logic signed [25:0] el_r, er_r;
  logic signed [15:0] v_r, d_r, l_r, r_r, k_r, c_r;
  logic signed [42:0] p_r;
  twmc_pkg::out_req_t out_r;
  logic               out_valid_r;

  // Counts of the held request at the state width
  logic signed [63:0]   lc64, rc64, mc64;
  logic signed [CB-1:0] lc, rc, mc;

  assign lc64 = 64'(in_r.left_count);
  assign rc64 = 64'(in_r.right_count);
  assign mc64 = 64'(in_r.move_counts);
  assign lc   = lc64[CB-1:0];
  assign rc   = rc64[CB-1:0];
  assign mc   = mc64[CB-1:0];

  // Error, speed and drift differences (wrap at the state width)
  logic signed [CB-1:0] el_w, er_w, dl_w, dr_w, vd_w, tl_w, tr_w, dd_w;

  assign el_w = lt_r - lc;
  assign er_w = rt_r - rc;
  assign dl_w = lc - lp_r;
  assign dr_w = rc - rp_r;
  assign vd_w = dl_w - dr_w;
  assign tl_w = lc - lo_r;
  assign tr_w = rc - ro_r;
  assign dd_w = tl_w - tr_w;

  // Shared multiplier, operands picked by the step
  logic [twmc_pkg::GAIN_W-1:0] mul_g;
  logic signed [25:0]          mul_x;
  logic signed [42:0]          prod;
  logic signed [15:0]          q;

  always_comb begin
    mul_g = '0;
    mul_x = '0;
    case (step)
      twmc_pkg::STEP_ML: begin
        mul_g = lpg_r;
        mul_x = el_r;
      end
      twmc_pkg::STEP_MR: begin
        mul_g = rpg_r;
        mul_x = er_r;
      end
      twmc_pkg::STEP_MV: begin
        mul_g = sg_r;
        mul_x = 26'(v_r);
      end
      twmc_pkg::STEP_MK: begin
        mul_g = dg_r;
        mul_x = 26'(d_r);
      end
      twmc_pkg::STEP_MC: begin
        mul_g = sg_r;
        mul_x = 26'(v_r);
      end
      default: begin
        mul_g = '0;
        mul_x = '0;
      end
    endcase
  end

  assign prod = $signed({1'b0, mul_g}) * mul_x;
  assign q    = qscale(p_r);

  // Speed-difference correction
  logic signed [15:0] l_s, r_s;

  always_comb begin
    l_s = l_r;
    r_s = r_r;
    if (v_r > 0) begin
      if (l_r > 0) l_s = sub_sat(l_r, c_r);
      else l_s = add_sat(l_r, c_r);
    end else begin
      if (r_r > 0) r_s = sub_sat(r_r, c_r);
      else l_s = add_sat(l_r, c_r);
    end
  end

  // Drift correction (drive mode) and direction clamps
  logic signed [15:0] l_d, r_d, l_f, r_f;

  always_comb begin
    l_d = l_r;
    r_d = r_r;
    if (!turn_r) begin
      if (fwd_r) begin
        if (d_r > 0) begin
          if (l_r > 0) l_d = sub_sat(l_r, k_r);
          else r_d = add_sat(r_r, k_r);
        end else begin
          if (r_r > 0) r_d = sub_sat(r_r, k_r);
          else l_d = add_sat(l_r, k_r);
        end
      end else begin
        if (d_r > 0) begin
          if (l_r < 0) l_d = sub_sat(l_r, k_r);
          else r_d = add_sat(r_r, k_r);
        end else begin
          if (r_r < 0) r_d = add_sat(r_r, k_r);
          else l_d = sub_sat(l_r, k_r);
        end
      end
    end
    if (fwd_r) begin
      l_f = clamp16(l_d, 16'sd0, twmc_pkg::L_MAX);
      r_f = turn_r ? clamp16(r_d, twmc_pkg::R_MIN, 16'sd0)
                   : clamp16(r_d, 16'sd0, twmc_pkg::R_MAX);
    end else begin
      l_f = clamp16(l_d, twmc_pkg::L_MIN, 16'sd0);
      r_f = turn_r ? clamp16(r_d, 16'sd0, twmc_pkg::R_MAX)
                   : clamp16(r_d, twmc_pkg::R_MIN, 16'sd0);
    end
  end

  // Stall timer
  logic        run, hit, expired, done_w;
  logic [31:0] elapsed;

  assign run     = (in_r.operation == twmc_pkg::OP_TICK) && active_r;
  assign hit     = (lc == lp_r) || (rc == rp_r);
  assign elapsed = in_r.now_ms - stamp_r;
  assign expired = elapsed > {16'd0, stall_ms_r};
  assign done_w  = run && hit && armed_r && expired;

  // Control and move state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpg_r       <= twmc_pkg::RST_POS_GAIN;
      rpg_r       <= twmc_pkg::RST_POS_GAIN;
      sg_r        <= twmc_pkg::RST_SYNC_GAIN;
      dg_r        <= twmc_pkg::RST_DRIFT_GAIN;
      stall_ms_r  <= twmc_pkg::RST_STALL_MS;
      lt_r        <= '0;
      rt_r        <= '0;
      lo_r        <= '0;
      ro_r        <= '0;
      lp_r        <= '1;
      rp_r        <= '1;
      armed_r     <= 1'b0;
      stamp_r     <= '0;
      fwd_r       <= 1'b0;
      turn_r      <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          twmc_pkg::CFG_LEFT_GAIN:  lpg_r      <= cfg_data;
          twmc_pkg::CFG_RIGHT_GAIN: rpg_r      <= cfg_data;
          twmc_pkg::CFG_SYNC_GAIN:  sg_r       <= cfg_data;
          twmc_pkg::CFG_DRIFT_GAIN: dg_r       <= cfg_data;
          twmc_pkg::CFG_STALL_MS:   stall_ms_r <= cfg_data;
          default: ;
        endcase
      end

      if (step == twmc_pkg::STEP_FIN) begin
        if (in_r.operation == twmc_pkg::OP_START) begin
          turn_r   <= in_r.turn_mode;
          fwd_r    <= in_r.move_counts > 0;
          lo_r     <= lc;
          ro_r     <= rc;
          lt_r     <= lc + mc;
          rt_r     <= in_r.turn_mode ? (rc - mc) : (rc + mc);
          lp_r     <= '1;
          rp_r     <= '1;
          armed_r  <= 1'b0;
          stamp_r  <= '0;
          active_r <= 1'b1;
        end else if (active_r) begin
          if (hit) begin
            if (!armed_r) begin
              stamp_r <= in_r.now_ms;
              armed_r <= 1'b1;
            end else if (expired) begin
              armed_r <= 1'b0;
            end
          end
          if (done_w) begin
            active_r <= 1'b0;
          end else begin
            lp_r <= lc;
            rp_r <= rc;
          end
        end
      end

      // Output register valid
      if (step == twmc_pkg::STEP_FIN) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Working registers and payloads
  always_ff @(posedge clk) begin
    case (step)
      twmc_pkg::STEP_LOAD: in_r <= in_data;
      twmc_pkg::STEP_PREP: begin
        el_r <= clamp_err(64'(el_w));
        er_r <= clamp_err(64'(er_w));
        v_r  <= sat16(64'(vd_w));
        d_r  <= sat16(64'(dd_w));
      end
      twmc_pkg::STEP_MR: l_r <= clamp16(q, twmc_pkg::L_MIN, twmc_pkg::L_MAX);
      twmc_pkg::STEP_MV: r_r <= clamp16(q, twmc_pkg::R_MIN, twmc_pkg::R_MAX);
      twmc_pkg::STEP_MK: begin
        // a large raw speed product leaves the difference unscaled
        if (!(p_r > twmc_pkg::SYNC_LIMIT)) v_r <= q;
      end
      twmc_pkg::STEP_MC: k_r <= q;
      twmc_pkg::STEP_WC: c_r <= q;
      twmc_pkg::STEP_SYNC: begin
        l_r <= l_s;
        r_r <= r_s;
      end
      twmc_pkg::STEP_FIN: begin
        if (run && !done_w) begin
          out_r.left_drive  <= l_f[7:0];
          out_r.right_drive <= r_f[7:0];
        end else begin
          out_r.left_drive  <= 8'sd0;
          out_r.right_drive <= 8'sd0;
        end
        out_r.done_res <= done_w;
      end
      default: ;
    endcase
    p_r <= prod;
  end

  assign sts.run      = run;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

// File: src/twmc_ctrl.sv
// Controller: sequences one request through the datapath steps.
`timescale 1ns / 1ps

module twmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  twmc_pkg::dp_sts_t sts,
  output twmc_pkg::step_t   step
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_ML,
    S_MR,
    S_MV,
    S_MK,
    S_MC,
    S_WC,
    S_SYNC,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // Next state and step command
  always_comb begin
    state_nxt = state_r;
    step      = twmc_pkg::STEP_NONE;
    case (state_r)
      S_IDLE: begin
        // load only on a real handshake
        if (in_valid && in_ready_r) begin
          step      = twmc_pkg::STEP_LOAD;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        step      = twmc_pkg::STEP_PREP;
        state_nxt = sts.run ? S_ML : S_FIN;
      end
      S_ML: begin
        step      = twmc_pkg::STEP_ML;
        state_nxt = S_MR;
      end
      S_MR: begin
        step      = twmc_pkg::STEP_MR;
        state_nxt = S_MV;
      end
      S_MV: begin
        step      = twmc_pkg::STEP_MV;
        state_nxt = S_MK;
      end
      S_MK: begin
        step      = twmc_pkg::STEP_MK;
        state_nxt = S_MC;
      end
      S_MC: begin
        step      = twmc_pkg::STEP_MC;
        state_nxt = S_WC;
      end
      S_WC: begin
        step      = twmc_pkg::STEP_WC;
        state_nxt = S_SYNC;
      end
      S_SYNC: begin
        step      = twmc_pkg::STEP_SYNC;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          step      = twmc_pkg::STEP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

// File: src/two_wheel_move_controller.sv
// Top level of the two-wheel move controller: controller, datapath and checks.
`timescale 1ns / 1ps

// Usage:
//   in_*  : valid/ready request channel. operation 0 starts a move from the
//           given counts (drive or turn), operation 1 is a control tick.
//   out_* : valid/ready result channel, exactly one result per request.
//   cfg_* : write port for the four Q8.8 gains and the stall time; write
//           only while the block is idle.
// Sequence: a tick during an active move goes from acceptance through operand
//   prep, five products through one shared 17x26 multiplier and the correction
//   steps to the result in the output register; a start or an idle tick goes
//   from operand prep straight to the result step. in_ready rises with the
//   result, and the next request can be accepted from then on.
// The output register holds a result while out_ready is low; the next
//   request is still accepted and works until its result step, where it
//   waits for the output register to free up.
// Reset (synchronous, rst_n low) restores register defaults, clears the
//   move so the block is idle, and drops out_valid.
// COUNT_BITS sets the width at which encoder counts and targets wrap.

module two_wheel_move_controller #(
  parameter int COUNT_BITS = twmc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  twmc_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output twmc_pkg::out_req_t             out_data,
  input  logic                           cfg_we,
  input  logic [twmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twmc_pkg::GAIN_W-1:0]    cfg_data
);

  twmc_pkg::step_t   step;
  twmc_pkg::dp_sts_t sts;

  twmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .step     (step)
  );

  twmc_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // One request at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted request");

  // A result that ends the move carries zero drives
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |->
      out_data.left_drive == 8'sd0 && out_data.right_drive == 8'sd0)
    else $error("move end reported with nonzero drive");

  // Drives stay within the motor limits
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.left_drive >= -8'sd113 && out_data.left_drive <= 8'sd112 &&
      out_data.right_drive >= -8'sd127)
    else $error("drive outside motor limits");

  // The result step never overwrites a pending result
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    step == twmc_pkg::STEP_FIN |-> sts.out_free)
    else $error("result written while output register was full");

endmodule
